### rtl/bchv_pkg.sv
// ----------------------------------------------------------------------------
// bchv_pkg: shared types and constants for the block checksum header verifier
// Widths of the configuration register, the words and the result fields.
// ----------------------------------------------------------------------------
package bchv_pkg;

    localparam int CFG_W  = 17;
    localparam int WORD_W = 32;

    // reset value of the block size register, in bytes
    localparam logic [CFG_W-1:0] SIZE_RESET = 17'd512;

    // one word of the incoming block plus the values sampled with word 0
    typedef struct packed {
        logic [WORD_W-1:0] block_word;
        logic [WORD_W-1:0] expected_id;
        logic [WORD_W-1:0] expected_number;
    } t_item;

    // per-block verdict
    typedef struct packed {
        logic [WORD_W-1:0] computed_checksum;
        logic              header_valid;
        logic              size_error;
    } t_result;

endpackage

### rtl/bchv_if.sv
// ----------------------------------------------------------------------------
// bchv_if: valid/ready channels of the block checksum header verifier
// Block word channel in, verdict channel out.
// ----------------------------------------------------------------------------
interface bchv_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_word;
    logic [31:0] expected_id;
    logic [31:0] expected_number;

    modport source (output valid, output block_word, output expected_id,
                    output expected_number, input ready);
    modport sink   (input valid, input block_word, input expected_id,
                    input expected_number, output ready);
endinterface

interface bchv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] computed_checksum;
    logic        header_valid;
    logic        size_error;

    modport source (output valid, output computed_checksum, output header_valid,
                    output size_error, input ready);
    modport sink   (input valid, input computed_checksum, input header_valid,
                    input size_error, output ready);
endinterface

### rtl/bchv_accum.sv
// ----------------------------------------------------------------------------
// bchv_accum: per-word checksum accumulation and header compare
// Folds one registered word per cycle into the running negated sum, but may
// stall a last word, tracks header matches, loads the verdict register on it.
// ----------------------------------------------------------------------------
module bchv_accum #(
    parameter int MAX_BLOCK_BYTES = 65536,
    parameter int HEADER_BYTES    = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [bchv_pkg::CFG_W-1:0]   i_block_size,
    input  logic                         i_valid,
    input  bchv_pkg::t_item              i_item,
    output logic                         o_take,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output bchv_pkg::t_result            o_res
);

    localparam int MAX_WORDS = MAX_BLOCK_BYTES / 4;
    localparam int IW        = $clog2(MAX_WORDS);
    localparam int CW        = $clog2(MAX_WORDS + 1);
    localparam int SZW       = bchv_pkg::CFG_W - 2;
    localparam int SW        = (CW > SZW) ? CW : SZW;

    localparam logic [SW-1:0] MAXW_C = SW'(MAX_WORDS);
    localparam logic [bchv_pkg::CFG_W-1:0] HDR_C = HEADER_BYTES[bchv_pkg::CFG_W-1:0];

    // header word positions
    localparam logic [IW-1:0] POS_ID   = IW'(0);
    localparam logic [IW-1:0] POS_CSUM = IW'(1);
    localparam logic [IW-1:0] POS_NUM  = IW'(2);

    // running negated sum: starts at -1, i.e. the sum starts at 1
    localparam logic [31:0] NEG_INIT = 32'hFFFF_FFFF;

    logic [31:0]   r_neg;
    logic [IW-1:0] r_idx;
    logic [31:0]   r_stored;
    logic          r_id_ok;
    logic          r_num_ok;
    logic [31:0]   r_exp_num;
    logic          r_out_valid;
    bchv_pkg::t_result r_out;

    logic [31:0]   n_neg;
    logic [31:0]   n_stored;
    logic          n_id_ok;
    logic          n_num_ok;
    logic [31:0]   n_exp_num;
    logic [SW-1:0] size_words;
    logic [SW-1:0] clamp_words;
    logic [CW-1:0] blk_words;
    logic          is_last;
    logic          size_bad;
    bchv_pkg::t_result res;

    // block length in words: max(1, min(size, max) / 4)
    always_comb begin
        size_words  = SW'(i_block_size[bchv_pkg::CFG_W-1:2]);
        clamp_words = (size_words > MAXW_C) ? MAXW_C : size_words;
        blk_words   = (clamp_words == '0) ? CW'(1) : CW'(clamp_words);
        is_last     = (CW'(r_idx) + CW'(1)) >= blk_words;
        size_bad    = (i_block_size < HDR_C) || (i_block_size[1:0] != 2'b00);
    end

    // stall only a last word while the verdict register is still full
    assign o_take = i_valid && !(is_last && r_out_valid && !i_res_ready);

    // next state for the current word
    always_comb begin
        n_neg     = (r_idx == POS_CSUM) ? r_neg : (r_neg - i_item.block_word);
        n_stored  = (r_idx == POS_CSUM) ? i_item.block_word : r_stored;
        n_id_ok   = (r_idx == POS_ID) ? (i_item.block_word == i_item.expected_id)
                                      : r_id_ok;
        n_exp_num = (r_idx == POS_ID) ? i_item.expected_number : r_exp_num;
        n_num_ok  = (r_idx == POS_NUM) ? (i_item.block_word == r_exp_num) : r_num_ok;

        if (size_bad) begin
            res.computed_checksum = '0;
            res.header_valid      = 1'b0;
            res.size_error        = 1'b1;
        end else begin
            res.computed_checksum = n_neg;
            res.header_valid      = n_id_ok && n_num_ok && (n_stored == n_neg);
            res.size_error        = 1'b0;
        end
    end

    // block state, rearmed after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg     <= NEG_INIT;
            r_idx     <= '0;
            r_stored  <= '0;
            r_id_ok   <= 1'b0;
            r_num_ok  <= 1'b0;
            r_exp_num <= '0;
        end else if (o_take) begin
            if (is_last) begin
                r_neg     <= NEG_INIT;
                r_idx     <= '0;
                r_stored  <= '0;
                r_id_ok   <= 1'b0;
                r_num_ok  <= 1'b0;
                r_exp_num <= '0;
            end else begin
                r_neg     <= n_neg;
                r_idx     <= r_idx + IW'(1);
                r_stored  <= n_stored;
                r_id_ok   <= n_id_ok;
                r_num_ok  <= n_num_ok;
                r_exp_num <= n_exp_num;
            end
        end
    end

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && is_last) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && is_last) begin
            r_out <= res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### rtl/block_checksum_header_verifier.sv
// ----------------------------------------------------------------------------
// block_checksum_header_verifier: negated word-sum block checksum checker
// Streams a block word by word; reports checksum, header match and size error.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | word
//  ---------+-----+--------------+-------------------------------------------
//  i_blk    | in  | valid/ready  | block_word, expected_id, expected_number
//  o_res    | out | valid/ready  | computed_checksum, header_valid, size_error
//  i_cfg_*  | in  | write enable | block size in bytes
//
//  One word per cycle sustained unless a stalled verdict holds back a last
//  word. The last word of a block lands in the input register and then loads
//  the verdict register. The accumulate stage has a single 32-bit subtract.
//  Synchronous active-low reset; block size resets to 512 bytes.
//  A stalled verdict holds the last word of the next block in the input
//  register, which then blocks further words until the verdict is taken.
// ----------------------------------------------------------------------------
module block_checksum_header_verifier #(
    parameter int MAX_BLOCK_BYTES = 65536,
    parameter int HEADER_BYTES    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bchv_pkg::CFG_W-1:0] i_cfg_wdata,
    bchv_in_if.sink                    i_blk,
    bchv_out_if.source                 o_res
);

    logic [bchv_pkg::CFG_W-1:0] r_block_size;
    logic                       r_in_valid;
    bchv_pkg::t_item            r_in;
    logic                       take;
    logic                       res_valid;
    bchv_pkg::t_result          res;

    // block size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= bchv_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_block_size <= i_cfg_wdata;
        end
    end

    // input register
    assign i_blk.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_blk.valid && i_blk.ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_blk.valid && i_blk.ready) begin
            r_in.block_word      <= i_blk.block_word;
            r_in.expected_id     <= i_blk.expected_id;
            r_in.expected_number <= i_blk.expected_number;
        end
    end

    bchv_accum #(
        .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_valid      (r_in_valid),
        .i_item       (r_in),
        .o_take       (take),
        .o_res_valid  (res_valid),
        .i_res_ready  (o_res.ready),
        .o_res        (res)
    );

    assign o_res.valid             = res_valid;
    assign o_res.computed_checksum = res.computed_checksum;
    assign o_res.header_valid      = res.header_valid;
    assign o_res.size_error        = res.size_error;

endmodule

### rtl/bchv_checker.sv
// ----------------------------------------------------------------------------
// bchv_checker: port-level checks for the block checksum header verifier
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module bchv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_checksum,
    input logic        i_header_valid,
    input logic        i_size_error
);

    // reset empties the verdict register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict valid after reset");

    // a stalled verdict holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_checksum) && $stable(i_header_valid)
             && $stable(i_size_error)))
        else $error("stalled verdict changed");

    // a size error forces a zero checksum and no header match
    a_size_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_size_error) |-> (i_checksum == 32'd0 && !i_header_valid))
        else $error("size error verdict carries data");

    // a fresh verdict follows an accepted word via the input and verdict registers
    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("verdict without a preceding word");

endmodule

bind block_checksum_header_verifier bchv_checker u_bchv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_blk.valid),
    .i_in_ready     (i_blk.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_checksum     (o_res.computed_checksum),
    .i_header_valid (o_res.header_valid),
    .i_size_error   (o_res.size_error)
);

### sim/block_checksum_header_verifier_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_checksum_header_verifier_tb: self-checking bench for the block verifier
// Streams whole blocks at many block sizes with random gaps and stalls.
// A local model folds each accepted word and queues its verdict or a typed one.
// Each verdict that comes out is compared, field by field, with that queue.
// ----------------------------------------------------------------------------
module block_checksum_header_verifier_tb;

    localparam int MAX_BLOCK_BYTES = 65536;
    localparam int HEADER_BYTES    = 12;
    localparam int RANDOM_WORDS    = 1040;
    localparam int DRAIN_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_MSGS        = 50;

    // block size register value
    typedef logic [bchv_pkg::CFG_W-1:0] t_size;

    // content of a random block
    typedef enum {BLK_GOOD, BLK_BAD_ID, BLK_BAD_NUM, BLK_BAD_SUM, BLK_NOISE} t_blk_kind;

    // directed stimulus row; the verdict is typed in only on the last word
    typedef struct {
        bit          set_size;
        int unsigned blk_bytes;
        logic [31:0] word;
        logic [31:0] id;
        logic [31:0] num;
        bit          typed;
        logic [31:0] ck;
        bit          hv;
        bit          se;
    } t_row;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    t_size cfg_wdata;

    bchv_in_if  blk_if ();
    bchv_out_if res_if ();

    block_checksum_header_verifier #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_blk      (blk_if),
        .o_res      (res_if)
    );

    // 20 ns clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // model state
    t_size            size_reg = bchv_pkg::SIZE_RESET;
    logic [31:0]      acc_sum = 32'd1;
    int unsigned      word_pos = 0;
    logic [31:0]      ck_stored = '0;
    bit               id_ok = 1'b0;
    bit               num_ok = 1'b0;
    logic [31:0]      num_latch = '0;

    bchv_pkg::t_result verdicts_due[$];
    bit      idle_on = 1'b1;
    int      errors = 0;
    int      cycles = 0;
    int      words_sent = 0;
    int      verdicts_seen = 0;
    int      good_headers = 0;
    int      size_errors = 0;
    int      size_writes = 0;
    t_row    dir_rows[24];

    function automatic int unsigned words_per_block(t_size sz);
        int unsigned eff;
        eff = (sz > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : sz;
        return (eff / 4 == 0) ? 1 : eff / 4;
    endfunction

    function automatic bit size_invalid(t_size sz);
        return (sz < HEADER_BYTES) || (sz[1:0] != 2'b00);
    endfunction

    // fold one word into the running block; done marks the last word
    task automatic accumulate_word(input bchv_pkg::t_item it, output bit done,
                                   output bchv_pkg::t_result res);
        logic [31:0] ck;
        if (word_pos == 0) begin
            id_ok     = (it.block_word == it.expected_id);
            num_latch = it.expected_number;
        end else if (word_pos == 2) begin
            num_ok = (it.block_word == num_latch);
        end
        if (word_pos == 1) ck_stored = it.block_word;
        else               acc_sum   = acc_sum + it.block_word;
        res  = '0;
        done = (word_pos + 1 >= words_per_block(size_reg));
        if (!done) begin
            word_pos++;
        end else begin
            ck = 32'd0 - acc_sum;
            if (size_invalid(size_reg)) begin
                res.size_error = 1'b1;
            end else begin
                res.computed_checksum = ck;
                res.header_valid      = id_ok && num_ok && (ck_stored == ck);
            end
            acc_sum   = 32'd1;
            word_pos  = 0;
            ck_stored = '0;
            id_ok     = 1'b0;
            num_ok    = 1'b0;
            num_latch = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_MSGS)
            $display("MISMATCH @%0t: %s got %h expected %h", $time, what, got, want);
    endtask

    // drive one word, wait for it to be taken, then queue any verdict
    task automatic send_word(input bchv_pkg::t_item it, input bit typed,
                             input bchv_pkg::t_result want);
        int                gap;
        bit                done;
        bchv_pkg::t_result res;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0) begin
            blk_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        blk_if.valid           <= 1'b1;
        blk_if.block_word      <= it.block_word;
        blk_if.expected_id     <= it.expected_id;
        blk_if.expected_number <= it.expected_number;
        do @(posedge clk); while (!blk_if.ready);
        words_sent++;
        accumulate_word(it, done, res);
        if (done) verdicts_due.push_back(typed ? want : res);
    endtask

    // drop valid and let every pending verdict come out
    task automatic drain_pipe();
        @(negedge clk);
        blk_if.valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_block_size(input t_size sz);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= sz;
        @(negedge clk);
        cfg_we   <= 1'b0;
        size_reg = sz;
        size_writes++;
    endtask

    function automatic t_blk_kind pick_kind();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            6:       return BLK_BAD_ID;
            7:       return BLK_BAD_NUM;
            8:       return BLK_BAD_SUM;
            9:       return BLK_NOISE;
            default: return BLK_GOOD;
        endcase
    endfunction

    // one whole block: mostly well formed, else one broken field or random noise
    task automatic send_block(input int unsigned n);
        logic [31:0]     w[];
        logic [31:0]     id;
        logic [31:0]     num;
        logic [31:0]     sum;
        t_blk_kind       kind;
        bchv_pkg::t_item it;
        w    = new[n];
        kind = pick_kind();
        id   = $urandom;
        num  = $urandom;
        foreach (w[i]) w[i] = $urandom;
        if (kind != BLK_NOISE) begin
            w[0] = id;
            if (n > 2) w[2] = num;
            sum = 32'd1;
            foreach (w[i]) if (i != 1) sum = sum + w[i];
            if (n > 1) w[1] = 32'd0 - sum;
            case (kind)
                BLK_BAD_ID:  id = id ^ (32'h1 << $urandom_range(0, 31));
                BLK_BAD_NUM: num = num ^ (32'h1 << $urandom_range(0, 31));
                BLK_BAD_SUM: if (n > 1) w[1] = w[1] ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
        end
        foreach (w[i]) begin
            it.block_word      = w[i];
            it.expected_id     = (i == 0) ? id : $urandom;
            it.expected_number = (i == 0) ? num : $urandom;
            send_word(it, 1'b0, '0);
        end
    endtask

    // verdict checker
    task automatic check_verdict();
        bchv_pkg::t_result want;
        if (verdicts_due.size() == 0) begin
            report_mismatch("verdict with none pending, checksum",
                            res_if.computed_checksum, '0);
            return;
        end
        want = verdicts_due.pop_front();
        if (res_if.computed_checksum !== want.computed_checksum)
            report_mismatch("computed_checksum", res_if.computed_checksum,
                            want.computed_checksum);
        if (res_if.header_valid !== want.header_valid)
            report_mismatch("header_valid", {31'd0, res_if.header_valid},
                            {31'd0, want.header_valid});
        if (res_if.size_error !== want.size_error)
            report_mismatch("size_error", {31'd0, res_if.size_error}, {31'd0, want.size_error});
        verdicts_seen++;
        if (want.header_valid) good_headers++;
        if (want.size_error)   size_errors++;
    endtask

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) check_verdict();
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d verdicts pending", cycles,
                     verdicts_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // verdict side: random stall before each verdict word while idle_on is set
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
        end
    end

    // main sequence
    initial begin
        bchv_pkg::t_item   it;
        bchv_pkg::t_result want;
        int                rand_start;
        t_size             sz;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        blk_if.valid           = 1'b0;
        blk_if.block_word      = '0;
        blk_if.expected_id     = '0;
        blk_if.expected_number = '0;
        res_if.ready           = 1'b0;

        // set, bytes, word, id, num, typed, checksum, valid, size error
        dir_rows = '{
            // 3-word blocks: good header, fields on later words ignored
            '{1, 12, 32'hDEADBEEF, 32'hDEADBEEF, 32'h0000_0000, 0, 32'h0, 0, 0},
            '{0, 0,  32'h21524110, 32'h12345678, 32'h87654321, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 32'h21524110, 1, 0},
            // all ones
            '{0, 0,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000001, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'hFFFFFFFF, 32'h0, 32'h0, 1, 32'h00000001, 1, 0},
            // sum wraps to zero, checksum zero
            '{0, 0,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 1, 32'h0, 1, 0},
            // type id mismatch
            '{0, 0,  32'h00000000, 32'h00000001, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'hFFFFFFFF, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 1, 32'hFFFFFFFF, 0, 0},
            // block number mismatch
            '{0, 0,  32'h00000000, 32'h0, 32'h80000000, 0, 32'h0, 0, 0},
            '{0, 0,  32'hFFFFFFFF, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 1, 32'hFFFFFFFF, 0, 0},
            // stored checksum wrong
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 1, 32'hFFFFFFFF, 0, 0},
            // zero size: one-word block, size error
            '{1, 0,  32'hA5A5A5A5, 32'hA5A5A5A5, 32'h0, 1, 32'h0, 0, 1},
            // below header size: two words
            '{1, 8,  32'h5A5A5A5A, 32'h5A5A5A5A, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'hC3C3C3C3, 32'h0, 32'h0, 1, 32'h0, 0, 1},
            // unaligned size with an otherwise good header
            '{1, 13, 32'hDEADBEEF, 32'hDEADBEEF, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h21524110, 32'h0, 32'h0, 0, 32'h0, 0, 0},
            '{0, 0,  32'h00000000, 32'h0, 32'h0, 1, 32'h0, 0, 1}
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one block at the power-up block size
        send_block(words_per_block(size_reg));

        // directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].set_size) begin
                drain_pipe();
                write_block_size(t_size'(dir_rows[k].blk_bytes));
            end
            it.block_word          = dir_rows[k].word;
            it.expected_id         = dir_rows[k].id;
            it.expected_number     = dir_rows[k].num;
            want.computed_checksum = dir_rows[k].ck;
            want.header_valid      = dir_rows[k].hv;
            want.size_error        = dir_rows[k].se;
            send_word(it, dir_rows[k].typed, want);
        end

        // random phases: mostly small aligned sizes, some bad ones
        rand_start = words_sent;
        while (words_sent - rand_start < RANDOM_WORDS) begin
            drain_pipe();
            case ($urandom_range(0, 9))
                0: sz = t_size'($urandom_range(0, HEADER_BYTES - 1));
                1: begin
                    sz = t_size'($urandom_range(13, 127));
                    if (sz[1:0] == 2'b00) sz = sz + t_size'(1);
                end
                default: sz = t_size'(4 * $urandom_range(3, 64));
            endcase
            write_block_size(sz);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 6)) send_block(words_per_block(size_reg));
        end

        drain_pipe();
        $display("Sent %0d words over %0d block sizes; %0d verdicts checked",
                 words_sent, size_writes, verdicts_seen);
        $display("Verdicts with good header: %0d, with size error: %0d",
                 good_headers, size_errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bchv_pkg.sv
rtl/bchv_if.sv
rtl/bchv_accum.sv
rtl/block_checksum_header_verifier.sv
rtl/bchv_checker.sv
sim/block_checksum_header_verifier_tb.sv
